@@ hdl/sfp_pkg.sv @@
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int DEF_MAX_PAYLOAD = 8;

  localparam logic [1:0] CMD_RX_BYTE   = 2'd0;
  localparam logic [1:0] CMD_CLR_ROUND = 2'd1;
  localparam logic [1:0] CMD_CLR_SNAP  = 2'd2;

  localparam logic [1:0] CFG_START_BYTE = 2'd0;
  localparam logic [1:0] CFG_END_BYTE   = 2'd1;
  localparam logic [1:0] CFG_STATUS_OP  = 2'd2;

  localparam logic [7:0] RST_START_BYTE = 8'd170;
  localparam logic [7:0] RST_END_BYTE   = 8'd85;
  localparam logic [7:0] RST_STATUS_OP  = 8'd1;

  localparam logic [7:0] TRIGGERED_STATE = 8'h03;
  localparam logic [7:0] MAX_ADDR        = 8'd31;
  localparam logic [3:0] STATUS_LEN      = 4'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       streaming_active;
  } in_item_t;

  typedef struct packed {
    logic [31:0] round_alive;
    logic [31:0] round_triggered;
    logic [31:0] snap_alive;
    logic [31:0] snap_triggered;
    logic        status_applied;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte_value;
    logic [7:0] status_opcode;
  } cfg_t;

endpackage

@@ hdl/sfp_chan_if.sv @@
`timescale 1ns / 1ps

interface sfp_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sfp_cfg_regs.sv @@
`timescale 1ns / 1ps

module sfp_cfg_regs import sfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cfg_write_t wr,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte     <= RST_START_BYTE;
      cfg_r.end_byte_value <= RST_END_BYTE;
      cfg_r.status_opcode  <= RST_STATUS_OP;
    end else if (wr_en) begin
      case (wr.index)
        CFG_START_BYTE: cfg_r.start_byte     <= wr.data;
        CFG_END_BYTE:   cfg_r.end_byte_value <= wr.data;
        CFG_STATUS_OP:  cfg_r.status_opcode  <= wr.data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/sfp_in_reg.sv @@
`timescale 1ns / 1ps

module sfp_in_reg import sfp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     item_valid,
  output in_item_t item,
  input  logic     item_take
);

  logic     valid_r;
  in_item_t item_r;

  assign in_ready = !valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hdl/sfp_core.sv @@
`timescale 1ns / 1ps

module sfp_core import sfp_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  in_item_t  item,
  output logic      item_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [3:0] MAX_LEN4 = 4'(MAX_PAYLOAD);
  localparam logic [7:0] MAX_LEN8 = 8'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_WAIT_SOF,
    PH_GOT_SOF,
    PH_WAIT_LEN,
    PH_COLLECT,
    PH_WAIT_END
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  store_r [MAX_PAYLOAD];
  logic        store_we;
  logic [31:0] ra_r, ra_nxt;
  logic [31:0] rt_r, rt_nxt;
  logic [31:0] sa_r, sa_nxt;
  logic [31:0] st_r, st_nxt;
  logic        applied;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [7:0]  b;
  logic [7:0]  addr;
  logic [7:0]  state_b;
  logic [31:0] node_bit;
  logic        trig;
  logic        frame_ok;
  logic        len_bad;

  assign item_take = item_valid && (!out_valid_r || out_ready);

  assign b        = item.rx_byte;
  assign addr     = store_r[1];
  assign state_b  = store_r[2];
  assign node_bit = 32'b1 << addr[4:0];
  assign trig     = (state_b == TRIGGERED_STATE);
  assign len_bad  = (b == 8'd0) || (b > MAX_LEN8);
  assign frame_ok = (b == cfg.end_byte_value) && (len_r == STATUS_LEN)
                 && (store_r[0] == cfg.status_opcode)
                 && (addr != 8'd0) && (addr <= MAX_ADDR) && (state_b != 8'd0);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    store_we  = 1'b0;
    ra_nxt    = ra_r;
    rt_nxt    = rt_r;
    sa_nxt    = sa_r;
    st_nxt    = st_r;
    applied   = 1'b0;
    case (item.cmd)
      CMD_RX_BYTE: begin
        case (phase_r)
          PH_WAIT_SOF: begin
            if (b == cfg.start_byte) phase_nxt = PH_GOT_SOF;
          end
          PH_GOT_SOF, PH_WAIT_LEN: begin
            if (phase_r == PH_GOT_SOF && b == cfg.start_byte) begin
              phase_nxt = PH_WAIT_LEN;
            end else begin
              idx_nxt = 4'd0;
              if (len_bad) begin
                len_nxt   = 4'd0;
                phase_nxt = PH_WAIT_SOF;
              end else begin
                len_nxt   = b[3:0];
                phase_nxt = PH_COLLECT;
              end
            end
          end
          PH_COLLECT: begin
            store_we = (idx_r < MAX_LEN4);
            idx_nxt  = idx_r + 4'd1;
            if (idx_nxt == len_r) phase_nxt = PH_WAIT_END;
          end
          PH_WAIT_END: begin
            phase_nxt = PH_WAIT_SOF;
            if (frame_ok) begin
              applied = 1'b1;
              ra_nxt  = ra_r | node_bit;
              rt_nxt  = trig ? (rt_r | node_bit) : (rt_r & ~node_bit);
              if (item.streaming_active) begin
                sa_nxt = sa_r | node_bit;
                st_nxt = trig ? (st_r | node_bit) : (st_r & ~node_bit);
              end
            end
          end
          default: phase_nxt = PH_WAIT_SOF;
        endcase
      end
      CMD_CLR_ROUND: begin
        ra_nxt = 32'd0;
        rt_nxt = 32'd0;
      end
      CMD_CLR_SNAP: begin
        sa_nxt = 32'd0;
        st_nxt = 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_SOF;
      len_r       <= 4'd0;
      idx_r       <= 4'd0;
      ra_r        <= 32'd0;
      rt_r        <= 32'd0;
      sa_r        <= 32'd0;
      st_r        <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        phase_r <= phase_nxt;
        len_r   <= len_nxt;
        idx_r   <= idx_nxt;
        ra_r    <= ra_nxt;
        rt_r    <= rt_nxt;
        sa_r    <= sa_nxt;
        st_r    <= st_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (item_take && store_we) begin
      store_r[idx_r[IDX_W-1:0]] <= b;
    end
    if (item_take) begin
      out_data_r.round_alive     <= ra_nxt;
      out_data_r.round_triggered <= rt_nxt;
      out_data_r.snap_alive      <= sa_nxt;
      out_data_r.snap_triggered  <= st_nxt;
      out_data_r.status_applied  <= applied;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/status_frame_parser.sv @@
`timescale 1ns / 1ps

// Status frame parser: takes one transfer per clock (a received byte or a mask-clear
// command) and returns exactly one result transfer per input, carrying the four node
// masks after that step and a flag for a completed status frame. An item is captured in
// an input register, processed against the parser state and registered in the output
// register; with out_ready high a result is taken at the following edge and the block
// sustains one item per cycle.
// in_ready drops only while both registers hold items and the output is stalled.
// Configuration writes are always ready and are registered before the core uses them.

module status_frame_parser import sfp_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input logic clk,
  input logic rst_n,
  sfp_chan_if.sink   in_ch,
  sfp_chan_if.source out_ch,
  sfp_chan_if.sink   cfg_ch
);

  cfg_t      cfg;
  logic      item_valid;
  in_item_t  item;
  logic      item_take;
  in_item_t  in_data;
  cfg_write_t cfg_wr;
  out_item_t out_data;

  assign in_data      = in_item_t'(in_ch.data);
  assign cfg_wr       = cfg_write_t'(cfg_ch.data);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.data  = out_data;

  sfp_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_ch.valid),
    .wr    (cfg_wr),
    .cfg   (cfg)
  );

  sfp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  sfp_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

endmodule
